// ===== rtl/mbg_pkg.sv =====
// package for the maze backtracker generator
// holds sizes, request codes, state enum and controller/datapath structs
`default_nettype none
package mbg_pkg;
    localparam int MAX_WIDTH  = 32;
    localparam int MAX_HEIGHT = 32;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = XW + YW;
    localparam int DW = AW + 1;
    // stack entry: x, y, order (4 x 2 bits), next (3 bits)
    localparam int SW = XW + YW + 8 + 3;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    localparam logic [1:0] REQ_CLEAR   = 2'd0;
    localparam logic [1:0] REQ_GEN     = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;
    localparam logic [1:0] REQ_IGNORED = 2'd3;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SEED   = 2'd2;

    localparam logic [1:0] DIR_TOP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT  = 2'd1;
    localparam logic [1:0] DIR_BOTTOM = 2'd2;
    localparam logic [1:0] DIR_LEFT   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_READ_WAIT, ST_READ_DONE, ST_ENTER, ST_SHUF,
        ST_PUSH, ST_TOP_RD, ST_TOP_EVAL, ST_NB_WAIT, ST_NB_EVAL, ST_CARVE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_req;
        logic clear_wr;
        logic cell_rd_req;
        logic read_capture;
        logic gen_start;
        logic enter_mark;
        logic shuffle_step;
        logic push;
        logic stack_rd;
        logic frame_eval;
        logic nb_rd;
        logic carve;
        logic result_load;
    } ctrl_t;

    typedef struct packed {
        logic clear_last;
        logic shuffle_last;
        logic stack_full;
        logic stack_empty;
        logic frame_pop;
        logic frame_skip;
        logic nb_ok;
        logic req_inside;
    } stat_t;
endpackage
`default_nettype wire

// ===== rtl/mbg_if.sv =====
// valid/ready channel interface for the maze backtracker generator
// payload type is given per instance; no package dependency
`default_nettype none
interface mbg_if #(parameter type payload_t = logic) (input wire logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/maze_backtracker_generator_top.sv =====
// top level of the maze backtracker generator
// depends on mbg_pkg, mbg_if, mbg_ctrl, mbg_datapath
`default_nettype none
// One request item in, one result item out, in order. After reset the block raises every
// wall before it takes its first item. A read fetches the cell and then gives its
// result; a clear writes one cell per cycle and then gives its result. A generate reads
// the start cell, then for each cell entered marks it, runs a four-draw shuffle and
// pushes a frame; each neighbor try fetches and checks the frame, then reads and tests
// the neighbor, a free neighbor is carved to, and a finished frame is dropped. A new
// item is accepted the cycle after a result is loaded; a result not yet taken holds the
// following one back. Cells hold four walls and a visited bit; configure size and seed
// only while no item is in flight.
module maze_backtracker_generator_top
    import mbg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    mbg_if.sink              req,
    mbg_if.source            rsp,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    logic [5:0]  width_reg, height_reg;
    logic [15:0] seed_reg;
    ctrl_t ct;
    stat_t st;
    logic idle, out_valid_reg, in_fire;
    logic [5:0] result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 6'd20;
            height_reg <= 6'd20;
            seed_reg   <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[5:0];
                REG_HEIGHT: height_reg <= cfg_data[5:0];
                REG_SEED:   seed_reg   <= cfg_data;
                default:    seed_reg   <= seed_reg;
            endcase
        end
    end

    assign req.ready = idle;
    assign in_fire = req.valid && idle;

    mbg_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .req_type(req.data.req_type),
        .out_busy(out_valid_reg && !rsp.ready), .st(st), .ct(ct), .idle(idle)
    );

    mbg_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .ct(ct), .req_type(req.data.req_type),
        .cell_x(req.data.cell_x), .cell_y(req.data.cell_y),
        .grid_width(width_reg), .grid_height(height_reg), .random_seed(seed_reg),
        .st(st), .result(result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ct.result_load)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ct.result_load)
        begin
            rsp.data.wall_top     <= result[0];
            rsp.data.wall_right   <= result[1];
            rsp.data.wall_bottom  <= result[2];
            rsp.data.wall_left    <= result[3];
            rsp.data.cell_visited <= result[4];
            rsp.data.status       <= result[5];
        end
    end
    assign rsp.valid = out_valid_reg;
endmodule
`default_nettype wire

// ===== rtl/mbg_ctrl.sv =====
// controller state machine for the maze backtracker generator
// depends on mbg_pkg
`default_nettype none
module mbg_ctrl
    import mbg_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_fire,
    input  wire logic [1:0] req_type,
    input  wire logic  out_busy,
    input  wire stat_t st,
    output ctrl_t      ct,
    output logic       idle
);
    state_t state_reg, state_next;
    logic [1:0] req_reg;
    logic boot_reg;

    // after reset the whole cell store is cleared before the first item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            req_reg   <= REQ_CLEAR;
            boot_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
                req_reg <= req_type;
            if (state_reg == ST_CLEAR && st.clear_last)
                boot_reg <= 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (req_type)
                        REQ_CLEAR: state_next = ST_CLEAR;
                        REQ_GEN:   state_next = ST_READ_WAIT;
                        REQ_READ:  state_next = ST_READ_WAIT;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (st.clear_last)
                    state_next = boot_reg ? ST_IDLE : ST_DONE;
            end
            // a generate first fetches the start cell
            ST_READ_WAIT: state_next = (req_reg == REQ_GEN) ? ST_ENTER : ST_READ_DONE;
            ST_READ_DONE: state_next = ST_DONE;
            ST_ENTER:
            begin
                if (!st.req_inside && req_reg == REQ_GEN)
                    state_next = ST_DONE;
                else if (st.stack_full)
                    state_next = st.stack_empty ? ST_DONE : ST_TOP_RD;
                else
                    state_next = ST_SHUF;
            end
            ST_SHUF:      if (st.shuffle_last) state_next = ST_PUSH;
            ST_PUSH:      state_next = ST_TOP_RD;
            ST_TOP_RD:    state_next = st.stack_empty ? ST_DONE : ST_TOP_EVAL;
            ST_TOP_EVAL:
            begin
                if (st.frame_pop || st.frame_skip)
                    state_next = ST_TOP_RD;
                else
                    state_next = ST_NB_WAIT;
            end
            ST_NB_WAIT:   state_next = ST_NB_EVAL;
            ST_NB_EVAL:   state_next = st.nb_ok ? ST_CARVE : ST_TOP_RD;
            ST_CARVE:     state_next = ST_ENTER;
            ST_DONE:      if (!out_busy) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ct = '0;
        idle = (state_reg == ST_IDLE);
        ct.load_req = idle && in_fire;
        ct.gen_start = idle && in_fire && req_type == REQ_GEN;
        case (state_reg)
            ST_CLEAR:     ct.clear_wr = 1'b1;
            ST_READ_WAIT: ct.cell_rd_req = 1'b1;
            ST_READ_DONE: ct.read_capture = 1'b1;
            ST_ENTER:
                ct.enter_mark = (st.req_inside || req_reg != REQ_GEN) && !st.stack_full;
            ST_SHUF:      ct.shuffle_step = 1'b1;
            ST_PUSH:      ct.push = 1'b1;
            ST_TOP_RD:    ct.stack_rd = !st.stack_empty;
            ST_TOP_EVAL:  ct.frame_eval = 1'b1;
            ST_NB_WAIT:   ct.nb_rd = 1'b1;
            ST_CARVE:     ct.carve = 1'b1;
            ST_DONE:      ct.result_load = !out_busy;
            default:      ;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/mbg_datapath.sv =====
// datapath: cell store, walk stack, lfsr, frame registers
// depends on mbg_pkg; driven by mbg_ctrl
`default_nettype none
module mbg_datapath
    import mbg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ctrl_t       ct,
    input  wire logic [1:0]  req_type,
    input  wire logic [4:0]  cell_x,
    input  wire logic [4:0]  cell_y,
    input  wire logic [5:0]  grid_width,
    input  wire logic [5:0]  grid_height,
    input  wire logic [15:0] random_seed,
    output stat_t            st,
    output logic [5:0]       result
);
    // cell memory: bit0 top, bit1 right, bit2 bottom, bit3 left, bit4 visited
    logic [4:0]  cell_mem [CELLS];
    logic [SW-1:0] stack_mem [CELLS];

    logic [XW:0] used_w;
    logic [YW:0] used_h;
    logic [1:0]  req_reg;
    logic [XW-1:0] x_reg, nx_reg;
    logic [YW-1:0] y_reg, ny_reg;
    logic [7:0]  order_reg;
    logic [1:0]  shuf_i_reg;
    logic [DW-1:0] depth_reg;
    logic [AW-1:0] clr_reg;
    logic [15:0] lfsr_reg;
    logic [4:0]  rd_reg;
    logic [4:0]  own_reg;
    logic [5:0]  res_reg;
    logic        inside_reg;
    logic [3:0]  here_reg, there_reg;
    logic        outside_nb;
    logic [SW-1:0] top_reg;

    assign used_w = (grid_width > 6'(MAX_WIDTH)) ? (XW+1)'(MAX_WIDTH) : (XW+1)'(grid_width);
    assign used_h = (grid_height > 6'(MAX_HEIGHT)) ? (YW+1)'(MAX_HEIGHT) : (YW+1)'(grid_height);

    logic [15:0] lfsr_step;
    assign lfsr_step = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);

    // draw mod 3: base-4 digit sum keeps the remainder since 4 = 1 mod 3
    logic [1:0] mod3;
    always_comb
    begin
        logic [4:0] dsum;
        logic [2:0] dsum2;
        dsum = '0;
        for (int k = 0; k < 8; k++)
            dsum = dsum + 5'(lfsr_step[2*k +: 2]);
        dsum2 = 3'(dsum[1:0]) + 3'(dsum[3:2]) + 3'(dsum[4]);
        if (dsum2 >= 3'd6)
            mod3 = 2'(dsum2 - 3'd6);
        else if (dsum2 >= 3'd3)
            mod3 = 2'(dsum2 - 3'd3);
        else
            mod3 = dsum2[1:0];
    end

    // draw mod (i+1), i in 0..3
    logic [1:0] rmod;
    always_comb
    begin
        case (shuf_i_reg)
            2'd3:    rmod = lfsr_step[1:0];
            2'd2:    rmod = mod3;
            2'd1:    rmod = {1'b0, lfsr_step[0]};
            default: rmod = 2'd0;
        endcase
    end

    logic [7:0] order_sw;
    always_comb
    begin
        logic [1:0] a, b;
        order_sw = order_reg;
        a = order_reg[2*shuf_i_reg +: 2];
        b = order_reg[2*rmod +: 2];
        order_sw[2*shuf_i_reg +: 2] = b;
        order_sw[2*rmod +: 2] = a;
    end

    // fields of the popped frame
    logic [XW-1:0] fx;
    logic [YW-1:0] fy;
    logic [7:0]    ford;
    logic [2:0]    fnext;
    logic [1:0]    fdir;
    assign {fx, fy, ford, fnext} = top_reg;
    assign fdir = ford[2*fnext[1:0] +: 2];

    logic [XW:0] cx;
    logic [YW:0] cy;
    logic [3:0]  here_c, there_c;
    logic        skip_c;
    always_comb
    begin
        cx = {1'b0, fx};
        cy = {1'b0, fy};
        skip_c = 1'b0;
        here_c = 4'd0;
        there_c = 4'd0;
        case (fdir)
            DIR_TOP:
            begin
                skip_c = (fy == '0);
                cy = {1'b0, fy} - 1'b1;
                here_c = 4'd1; there_c = 4'd4;
            end
            DIR_RIGHT:
            begin
                cx = {1'b0, fx} + 1'b1;
                here_c = 4'd2; there_c = 4'd8;
            end
            DIR_BOTTOM:
            begin
                cy = {1'b0, fy} + 1'b1;
                here_c = 4'd4; there_c = 4'd1;
            end
            default:
            begin
                skip_c = (fx == '0);
                cx = {1'b0, fx} - 1'b1;
                here_c = 4'd8; there_c = 4'd2;
            end
        endcase
    end

    assign st.clear_last   = (clr_reg == AW'(CELLS - 1));
    assign st.shuffle_last = (shuf_i_reg == 2'd0);
    assign st.stack_full   = (depth_reg == DW'(CELLS));
    assign st.stack_empty  = (depth_reg == '0);
    assign st.frame_pop    = fnext[2];
    assign st.frame_skip   = !fnext[2] && skip_c;
    assign st.nb_ok        = !outside_nb && !rd_reg[4];
    assign st.req_inside   = inside_reg;
    assign result = res_reg;

    logic [AW-1:0] cur_addr, nb_addr;
    assign cur_addr = {y_reg, x_reg};
    assign nb_addr  = {ny_reg, nx_reg};

    // memories; carve drops the wall on the current cell, the following enter
    // drops the facing wall on the neighbor and marks it visited
    always_ff @(posedge clk)
    begin
        if (ct.clear_wr)
            cell_mem[clr_reg] <= 5'h0F;
        else if (ct.enter_mark)
            cell_mem[cur_addr] <= (rd_reg & ~{1'b0, there_reg}) | 5'h10;
        else if (ct.carve)
            cell_mem[cur_addr] <= own_reg & ~{1'b0, here_reg};
        if (ct.cell_rd_req || ct.nb_rd)
            rd_reg <= cell_mem[ct.nb_rd ? nb_addr : cur_addr];
        if (ct.nb_rd)
            own_reg <= cell_mem[cur_addr];
        if (ct.push)
            stack_mem[depth_reg[AW-1:0]] <= {x_reg, y_reg, order_reg, 3'd0};
        else if (ct.frame_eval && !fnext[2])
            stack_mem[depth_reg[AW-1:0] - 1'b1] <= {fx, fy, ford, fnext + 3'd1};
        if (ct.stack_rd)
            top_reg <= stack_mem[depth_reg[AW-1:0] - 1'b1];
        else if (ct.push)
            top_reg <= {x_reg, y_reg, order_reg, 3'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= '0;
            clr_reg    <= '0;
            lfsr_reg   <= 16'd1;
            shuf_i_reg <= 2'd3;
        end
        else
        begin
            if (ct.load_req)
                clr_reg <= '0;
            else if (ct.clear_wr)
                clr_reg <= clr_reg + 1'b1;
            if (ct.gen_start)
                lfsr_reg <= random_seed;
            else if (ct.shuffle_step)
                lfsr_reg <= lfsr_step;
            if (ct.enter_mark)
                shuf_i_reg <= 2'd3;
            else if (ct.shuffle_step)
                shuf_i_reg <= shuf_i_reg - 1'b1;
            if (ct.load_req || ct.clear_wr)
                depth_reg <= '0;
            else if (ct.push)
                depth_reg <= depth_reg + 1'b1;
            else if (ct.frame_eval && fnext[2])
                depth_reg <= depth_reg - 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ct.load_req)
        begin
            req_reg    <= req_type;
            x_reg      <= XW'(cell_x);
            y_reg      <= YW'(cell_y);
            inside_reg <= ({1'b0, cell_x} < 6'(used_w)) && ({1'b0, cell_y} < 6'(used_h));
            res_reg    <= '0;
            there_reg  <= '0;
        end
        if (ct.enter_mark)
            order_reg <= 8'b11_10_01_00;
        else if (ct.shuffle_step)
            order_reg <= order_sw;
        if (ct.frame_eval)
        begin
            nx_reg     <= cx[XW-1:0];
            ny_reg     <= cy[YW-1:0];
            outside_nb <= (cx >= used_w) || (cy >= used_h);
            here_reg   <= here_c;
            there_reg  <= there_c;
            x_reg      <= fx;
            y_reg      <= fy;
        end
        if (ct.carve)
        begin
            x_reg <= nx_reg;
            y_reg <= ny_reg;
        end
        if (ct.read_capture)
        begin
            if (inside_reg)
                res_reg <= {1'b0, rd_reg[4], rd_reg[3], rd_reg[2], rd_reg[1], rd_reg[0]};
            else
                res_reg <= 6'b100000;
        end
        if (req_reg == REQ_GEN && !inside_reg && !ct.load_req)
            res_reg <= 6'b100000;
    end
endmodule
`default_nettype wire
